>>> rtl/balance_cascade_controller_core_assert.svh
// Assertion macros used by the checker file of the controller core.
`ifndef BALANCE_CASCADE_CONTROLLER_CORE_ASSERT_SVH
`define BALANCE_CASCADE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define BCC_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, ignored while reset is high.
`define BCC_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

>>> rtl/bcc_pkg.sv
package bcc_pkg;

  // Stream and configuration port widths.
  localparam int InDataW  = 72;
  localparam int OutDataW = 40;
  localparam int CfgIdxW  = 8;
  localparam int GainW    = 32;

  // Input field positions inside s_tdata.
  localparam int EncW    = 16;
  localparam int PitchW  = 17;
  localparam int RateW   = 16;
  localparam int EncLLsb = 0;
  localparam int EncRLsb = 16;
  localparam int PitchLsb = 32;
  localparam int RateLsb = 49;

  // Datapath widths.
  localparam int ErrW   = 17;
  localparam int FiltW  = 18;
  localparam int IntegW = 15;
  localparam int SumW   = 22;
  localparam int AbsW   = 21;
  localparam int MulAW  = 33;
  localparam int MulBW  = 25;
  localparam int ProdW  = 58;
  localparam int AccW   = 60;
  localparam int SpeedW = 16;
  localparam int DriveW = 11;
  localparam int MagW   = 10;
  localparam int DriveAW = 11;

  // Divide by ten as a multiply by ceil(2^24 / 10) and a shift.
  localparam int DivShift = 24;
  localparam logic [MulAW-1:0] DivMagic = MulAW'(1677722);

  // Q.24 and Q.32 fraction widths of the two loops.
  localparam int SpeedFrac = 24;
  localparam int DriveFrac = 32;

  localparam int IntegLimit = 10000;
  localparam int SpeedMax   = 32767;
  localparam int SpeedMin   = -32768;
  localparam int DriveLimit = 1000;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegUprightKp = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegUprightKd = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSpeedKp   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpeedKi   = CfgIdxW'(3);

  localparam logic [GainW-1:0] UprightKpReset = 32'd1056964608;
  localparam logic [GainW-1:0] UprightKdReset = 32'd4026532;
  localparam logic [GainW-1:0] SpeedKpReset   = 32'd922747;
  localparam logic [GainW-1:0] SpeedKiReset   = 32'd4614;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_UPDATE,
    ST_MUL_SKP,
    ST_MUL_SKI,
    ST_SUM_SPEED,
    ST_SAT_SPEED,
    ST_MUL_UKP,
    ST_MUL_UKD,
    ST_SUM_UP,
    ST_SAT_DRIVE,
    ST_OUT
  } state_t;

  // One strobe per datapath step.
  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul_div;
    logic upd_state;
    logic mul_skp;
    logic mul_ski;
    logic sum_speed;
    logic sat_speed;
    logic mul_ukp;
    logic mul_ukd;
    logic sum_up;
    logic sat_drive;
    logic load_out;
  } cmd_t;

endpackage

>>> rtl/balance_cascade_controller_core.sv
// m_tvalid is registered; it rises as the sequencer leaves ST_OUT, which waits for a free output register.
// One item at a time; the sequencer walks a single shared 33x25 multiplier.
// A result waiting in the output register does not stop the next item from being accepted.
// Reset (rst, synchronous, active high) restores the default gains, clears the speed
// filter and integrator state, and empties the output register.
module balance_cascade_controller_core
  import bcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input items: enc_delta_left [15:0], enc_delta_right [31:16],
  // pitch_angle [48:32], pitch_rate [64:49], zero fill above.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,
  // Result items: motor_reverse [0], drive_a [11:1], drive_b [21:12],
  // drive_signed [32:22], zero fill above.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  // Gain writes: index 0 upright_kp, 1 upright_kd, 2 speed_kp, 3 speed_ki.
  // Any other index is ignored. Writes are always taken.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [GainW-1:0]    cfg_data
);

  // The controller sequences one item at a time through these steps:
  // capture the item, form the filter numerator, divide by ten through the
  // multiplier, update the filter and clamped integrator, run the speed PI
  // as two products and a sum, saturate the speed output, run the upright PD
  // as two products and a sum, clamp the drive, and load the output register.
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  bcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath holds the gains, the loop state, the multiplier and the
  // output register.
  bcc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

>>> rtl/bcc_ctrl.sv
module bcc_ctrl
  import bcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_PREP;
      ST_PREP:      state_next = ST_DIV;
      ST_DIV:       state_next = ST_UPDATE;
      ST_UPDATE:    state_next = ST_MUL_SKP;
      ST_MUL_SKP:   state_next = ST_MUL_SKI;
      ST_MUL_SKI:   state_next = ST_SUM_SPEED;
      ST_SUM_SPEED: state_next = ST_SAT_SPEED;
      ST_SAT_SPEED: state_next = ST_MUL_UKP;
      ST_MUL_UKP:   state_next = ST_MUL_UKD;
      ST_MUL_UKD:   state_next = ST_SUM_UP;
      ST_SUM_UP:    state_next = ST_SAT_DRIVE;
      ST_SAT_DRIVE: state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_PREP:      cmd.prep      = 1'b1;
      ST_DIV:       cmd.mul_div   = 1'b1;
      ST_UPDATE:    cmd.upd_state = 1'b1;
      ST_MUL_SKP:   cmd.mul_skp   = 1'b1;
      ST_MUL_SKI:   cmd.mul_ski   = 1'b1;
      ST_SUM_SPEED: cmd.sum_speed = 1'b1;
      ST_SAT_SPEED: cmd.sat_speed = 1'b1;
      ST_MUL_UKP:   cmd.mul_ukp   = 1'b1;
      ST_MUL_UKD:   cmd.mul_ukd   = 1'b1;
      ST_SUM_UP:    cmd.sum_up    = 1'b1;
      ST_SAT_DRIVE: cmd.sat_drive = 1'b1;
      ST_OUT:       cmd.load_out  = out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

>>> rtl/bcc_datapath.sv
module bcc_datapath
  import bcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [InDataW-1:0]  s_tdata,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [GainW-1:0]    cfg_data,
  output logic [OutDataW-1:0] m_tdata
);

  logic [GainW-1:0] upright_kp;
  logic [GainW-1:0] upright_kd;
  logic [GainW-1:0] speed_kp;
  logic [GainW-1:0] speed_ki;

  logic signed [EncW-1:0]   enc_left;
  logic signed [EncW-1:0]   enc_right;
  logic signed [PitchW-1:0] pitch;
  logic signed [RateW-1:0]  rate;

  logic signed [FiltW-1:0]  filtered_error;
  logic signed [IntegW-1:0] error_integral;

  logic                     sum_neg;
  logic [AbsW-1:0]          sum_abs;
  logic signed [ProdW-1:0]  prod;
  logic signed [AccW-1:0]   acc;
  logic signed [SpeedW-1:0] speed_out;
  logic signed [DriveW-1:0] drive;

  logic signed [ErrW-1:0]   err;
  logic signed [SumW-1:0]   sum;
  logic signed [FiltW-1:0]  quot;
  logic signed [FiltW-1:0]  filt_next;
  logic signed [FiltW:0]    integ_sum;
  logic signed [IntegW-1:0] integ_next;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulBW-1:0]  diff;
  logic signed [AccW-1:0]   speed_biased;
  logic signed [AccW-SpeedFrac-1:0] speed_whole;
  logic signed [AccW-1:0]   drive_biased;
  logic signed [AccW-DriveFrac-1:0] drive_whole;
  logic [MagW-1:0]          mag;
  logic [MagW+2:0]          mag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      upright_kp <= UprightKpReset;
      upright_kd <= UprightKdReset;
      speed_kp   <= SpeedKpReset;
      speed_ki   <= SpeedKiReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegUprightKp: upright_kp <= cfg_data;
        RegUprightKd: upright_kd <= cfg_data;
        RegSpeedKp:   speed_kp   <= cfg_data;
        RegSpeedKi:   speed_ki   <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      enc_left  <= s_tdata[EncLLsb +: EncW];
      enc_right <= s_tdata[EncRLsb +: EncW];
      pitch     <= s_tdata[PitchLsb +: PitchW];
      rate      <= s_tdata[RateLsb +: RateW];
    end
  end

  // Numerator of the low-pass filter, split into sign and magnitude so the
  // divide by ten can truncate toward zero.
  assign err = ErrW'(enc_left) + ErrW'(enc_right);
  assign sum = SumW'(3) * SumW'(err) + SumW'(7) * SumW'(filtered_error);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sum_neg <= sum[SumW-1];
      sum_abs <= sum[SumW-1] ? AbsW'(-sum) : AbsW'(sum);
    end
  end

  assign quot      = $signed(prod[DivShift +: FiltW]);
  assign filt_next = sum_neg ? -quot : quot;
  assign integ_sum = (FiltW+1)'(error_integral) + (FiltW+1)'(filt_next);

  always_comb begin
    if (integ_sum > IntegLimit) begin
      integ_next = IntegW'(IntegLimit);
    end else if (integ_sum < -IntegLimit) begin
      integ_next = IntegW'(-IntegLimit);
    end else begin
      integ_next = integ_sum[IntegW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_error <= '0;
      error_integral <= '0;
    end else if (cmd.upd_state) begin
      filtered_error <= filt_next;
      error_integral <= integ_next;
    end
  end

  // Shared signed multiplier; the unsigned gains enter with a zero sign bit.
  assign diff = MulBW'(pitch) - (MulBW'(speed_out) <<< 8);

  always_comb begin
    mul_a = $signed({1'b0, upright_kd});
    mul_b = MulBW'(rate);
    priority if (cmd.mul_div) begin
      mul_a = $signed(DivMagic);
      mul_b = $signed(MulBW'(sum_abs));
    end else if (cmd.mul_skp) begin
      mul_a = $signed({1'b0, speed_kp});
      mul_b = MulBW'(filtered_error);
    end else if (cmd.mul_ski) begin
      mul_a = $signed({1'b0, speed_ki});
      mul_b = MulBW'(error_integral);
    end else if (cmd.mul_ukp) begin
      mul_a = $signed({1'b0, upright_kp});
      mul_b = diff;
    end else begin
      mul_a = $signed({1'b0, upright_kd});
      mul_b = MulBW'(rate);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_div || cmd.mul_skp || cmd.mul_ski || cmd.mul_ukp || cmd.mul_ukd) begin
      prod <= ProdW'(mul_a) * ProdW'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ski || cmd.mul_ukd) begin
      acc <= AccW'(prod);
    end else if (cmd.sum_speed) begin
      acc <= acc + AccW'(prod);
    end else if (cmd.sum_up) begin
      acc <= acc + (AccW'(prod) <<< 8);
    end
  end

  // Truncation toward zero: bias negative sums by one less than the scale.
  assign speed_biased = acc + (acc[AccW-1] ? AccW'((64'd1 << SpeedFrac) - 64'd1) : AccW'(0));
  assign speed_whole  = speed_biased[AccW-1:SpeedFrac];
  assign drive_biased = acc + (acc[AccW-1] ? AccW'((64'd1 << DriveFrac) - 64'd1) : AccW'(0));
  assign drive_whole  = drive_biased[AccW-1:DriveFrac];

  always_ff @(posedge clk) begin
    if (cmd.sat_speed) begin
      if (speed_whole > SpeedMax) begin
        speed_out <= SpeedW'(SpeedMax);
      end else if (speed_whole < SpeedMin) begin
        speed_out <= SpeedW'(SpeedMin);
      end else begin
        speed_out <= speed_whole[SpeedW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat_drive) begin
      if (drive_whole > DriveLimit) begin
        drive <= DriveW'(DriveLimit);
      end else if (drive_whole < -DriveLimit) begin
        drive <= DriveW'(-DriveLimit);
      end else begin
        drive <= drive_whole[DriveW-1:0];
      end
    end
  end

  assign mag  = drive[DriveW-1] ? MagW'(-drive) : MagW'(drive);
  assign mag5 = {1'b0, mag, 2'b00} + (MagW+3)'(mag);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= OutDataW'({drive, mag, mag5[MagW+2:2], drive[DriveW-1]});
    end
  end

endmodule

>>> rtl/bcc_checker.sv
`include "balance_cascade_controller_core_assert.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  logic [MagW-1:0]    out_b;
  logic [DriveAW-1:0] out_a;
  logic [MagW+2:0]    b_times5;

  assign out_b    = m_tdata[21:12];
  assign out_a    = m_tdata[11:1];
  assign b_times5 = {1'b0, out_b, 2'b00} + (MagW+3)'(out_b);

  `BCC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BCC_ASSERT_NOW(a_dir_sign, clk, rst, m_tvalid, m_tdata[0] == m_tdata[32])
  `BCC_ASSERT_NOW(a_mag_ratio, clk, rst, m_tvalid, (out_b <= 10'd1000) && (out_a == b_times5[MagW+2:2]))
  `BCC_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind balance_cascade_controller_core bcc_checker u_bcc_checker (.*);
